FILE: rtl/core/power_fault_energy_monitor_top_macros.svh
// Assertion macros used by the checker file pfem_checker.sv.
`ifndef POWER_FAULT_ENERGY_MONITOR_TOP_MACROS_SVH
`define POWER_FAULT_ENERGY_MONITOR_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define PFEM_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pfem: same-cycle check failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define PFEM_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pfem: next-cycle check failed");

`endif

FILE: rtl/core/pfem_pkg.sv
`timescale 1ns / 1ps

package pfem_pkg;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 31;

	localparam logic [14:0] CUR_LIMIT_RST  = 15'd20000;
	localparam logic [30:0] CUR_TLIMIT_RST = 31'd100000;
	localparam logic [15:0] VOL_LIMIT_RST  = 16'd0;
	localparam logic [30:0] VOL_TLIMIT_RST = 31'd100000;
	localparam logic [30:0] ACC_MAX        = 31'h7FFF_FFFF;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CUR_LIMIT  = 2'd0,
		REG_CUR_TLIMIT = 2'd1,
		REG_VOL_LIMIT  = 2'd2,
		REG_VOL_TLIMIT = 2'd3
	} cfg_idx_t;

	typedef enum logic [1:0] {
		ALU_SAT64,
		ALU_CLAMP31,
		ALU_SUB
	} alu_op_t;

	typedef struct packed {
		alu_op_t     op;
		logic [63:0] a;
		logic [63:0] b;
	} alu_req_t;

	typedef struct packed {
		logic [63:0] res;
		logic        gt;
	} alu_rsp_t;

endpackage

FILE: rtl/core/pfem_mul.sv
`timescale 1ns / 1ps

module pfem_mul
	import pfem_pkg::*;
(
	input  logic               clk,
	input  logic               en,
	input  logic [31:0]        a,
	input  logic signed [16:0] b,
	output logic [47:0]        p
);

	logic signed [49:0] full;
	logic [47:0]        p_q;

	assign full = $signed({1'b0, a}) * b;

	always_ff @(posedge clk) begin
		if (en) begin
			p_q <= full[47:0];
		end
	end

	assign p = p_q;

endmodule

FILE: rtl/core/pfem_alu.sv
`timescale 1ns / 1ps

module pfem_alu
	import pfem_pkg::*;
(
	input  alu_req_t req,
	output alu_rsp_t rsp
);

	logic [64:0] a_x;
	logic [64:0] b_x;
	logic [64:0] sum;
	logic        sub;

	always_comb begin
		sub = (req.op == ALU_SUB);
		a_x = {req.a[63], req.a};
		b_x = {req.b[63], req.b};
		if (sub) begin
			b_x = ~b_x;
		end
		sum = a_x + b_x + {64'd0, sub};

		unique case (req.op)
			ALU_SAT64: begin
				// overflow when the two top bits of the exact sum disagree
				if (sum[64] != sum[63]) begin
					rsp.res = sum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
				end else begin
					rsp.res = sum[63:0];
				end
			end
			ALU_CLAMP31: begin
				if (sum[64]) begin
					rsp.res = 64'd0;
				end else if (|sum[63:31]) begin
					rsp.res = {33'd0, ACC_MAX};
				end else begin
					rsp.res = {33'd0, sum[30:0]};
				end
			end
			ALU_SUB: begin
				rsp.res = sum[63:0];
			end
			default: begin
				rsp.res = sum[63:0];
			end
		endcase
		rsp.gt = !sum[64] && (|sum[63:0]);
	end

endmodule

FILE: rtl/core/power_fault_energy_monitor_top.sv
`timescale 1ns / 1ps
// in_stall holds off new samples until the DONE state loads the result word.
// The shared 65-bit adder makes five passes (two accumulator updates, two limit
// compares, one energy add).
// Reset (arst_n low, asynchronous): accumulators, energy sum and sample counter
// clear, limit registers return to their defaults, no word is pending.

module power_fault_energy_monitor_top
	import pfem_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [15:0]           elapsed_us,
	input  logic [15:0]           bus_reading,
	input  logic signed [15:0]    shunt_reading,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  over_current,
	output logic                  under_voltage,
	output logic signed [15:0]    shunt_value,
	output logic signed [63:0]    energy_total,
	output logic [7:0]            sample_count,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CUR,
		ST_CUR_CMP,
		ST_VOL,
		ST_VOL_CMP,
		ST_ENERGY,
		ST_DONE
	} state_t;

	state_t      state_q;

	logic [14:0] cur_limit_q;
	logic [30:0] cur_tlimit_q;
	logic [15:0] vol_limit_q;
	logic [30:0] vol_tlimit_q;

	logic [15:0] dt_q;
	logic [15:0] vbus_q;
	logic [15:0] shunt_q;
	logic        oc_grow_q;
	logic        uv_grow_q;

	logic [30:0] cur_time_q;
	logic [30:0] vol_time_q;
	logic [63:0] energy_q;
	logic [7:0]  cnt_q;
	logic        oc_q;
	logic        uv_q;

	logic        out_valid_q;
	logic        over_current_q;
	logic        under_voltage_q;
	logic [15:0] shunt_value_q;
	logic [63:0] energy_total_q;
	logic [7:0]  sample_count_q;

	logic        in_acc;
	logic [15:0] neg_shunt;
	logic [16:0] neg_ext;
	logic [16:0] shunt_mag;
	logic [63:0] dt_ext;
	logic [63:0] dt_neg;

	alu_req_t    alu_req;
	alu_rsp_t    alu_rsp;

	logic        mul_en;
	logic [31:0] mul_a;
	logic [16:0] mul_b;
	logic [47:0] mul_p;

	assign in_stall = (state_q != ST_IDLE);
	assign in_acc   = in_valid && !in_stall;

	// 16-bit wrap: the most negative reading stays most negative
	assign neg_shunt = 16'd0 - shunt_reading;
	assign neg_ext   = {neg_shunt[15], neg_shunt};
	assign shunt_mag = neg_shunt[15] ? (~neg_ext + 17'd1) : neg_ext;

	assign dt_ext = {48'd0, dt_q};
	assign dt_neg = ~dt_ext + 64'd1;

	always_comb begin
		alu_req.op = ALU_SAT64;
		alu_req.a  = 64'd0;
		alu_req.b  = 64'd0;
		unique case (state_q)
			ST_CUR: begin
				alu_req.op = ALU_CLAMP31;
				alu_req.a  = {33'd0, cur_time_q};
				alu_req.b  = oc_grow_q ? dt_ext : dt_neg;
			end
			ST_CUR_CMP: begin
				alu_req.op = ALU_SUB;
				alu_req.a  = {33'd0, cur_time_q};
				alu_req.b  = {33'd0, cur_tlimit_q};
			end
			ST_VOL: begin
				alu_req.op = ALU_CLAMP31;
				alu_req.a  = {33'd0, vol_time_q};
				alu_req.b  = uv_grow_q ? dt_ext : dt_neg;
			end
			ST_VOL_CMP: begin
				alu_req.op = ALU_SUB;
				alu_req.a  = {33'd0, vol_time_q};
				alu_req.b  = {33'd0, vol_tlimit_q};
			end
			ST_ENERGY: begin
				alu_req.op = ALU_SAT64;
				alu_req.a  = energy_q;
				alu_req.b  = {{16{mul_p[47]}}, mul_p};
			end
			ST_IDLE, ST_DONE: begin
				alu_req.op = ALU_SAT64;
			end
			default: begin
				alu_req.op = ALU_SAT64;
			end
		endcase
	end

	pfem_alu u_alu (
		.req (alu_req),
		.rsp (alu_rsp)
	);

	// first pass dt * vbus, second pass that product * shunt
	assign mul_en = (state_q == ST_CUR) || (state_q == ST_CUR_CMP);
	assign mul_a  = (state_q == ST_CUR) ? {16'd0, dt_q} : mul_p[31:0];
	assign mul_b  = (state_q == ST_CUR) ? {1'b0, vbus_q} : {shunt_q[15], shunt_q};

	pfem_mul u_mul (
		.clk (clk),
		.en  (mul_en),
		.a   (mul_a),
		.b   (mul_b),
		.p   (mul_p)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			cur_limit_q     <= CUR_LIMIT_RST;
			cur_tlimit_q    <= CUR_TLIMIT_RST;
			vol_limit_q     <= VOL_LIMIT_RST;
			vol_tlimit_q    <= VOL_TLIMIT_RST;
			dt_q            <= 16'd0;
			vbus_q          <= 16'd0;
			shunt_q         <= 16'd0;
			oc_grow_q       <= 1'b0;
			uv_grow_q       <= 1'b0;
			cur_time_q      <= 31'd0;
			vol_time_q      <= 31'd0;
			energy_q        <= 64'd0;
			cnt_q           <= 8'd0;
			oc_q            <= 1'b0;
			uv_q            <= 1'b0;
			out_valid_q     <= 1'b0;
			over_current_q  <= 1'b0;
			under_voltage_q <= 1'b0;
			shunt_value_q   <= 16'd0;
			energy_total_q  <= 64'd0;
			sample_count_q  <= 8'd0;
		end else begin
			if (cfg_wr_en) begin
				unique case (cfg_idx_t'(cfg_index))
					REG_CUR_LIMIT:  cur_limit_q  <= cfg_data[14:0];
					REG_CUR_TLIMIT: cur_tlimit_q <= cfg_data[30:0];
					REG_VOL_LIMIT:  vol_limit_q  <= cfg_data[15:0];
					REG_VOL_TLIMIT: vol_tlimit_q <= cfg_data[30:0];
				endcase
			end

			// the done state reloads the output register itself
			if (out_valid_q && !out_stall && state_q != ST_DONE) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						dt_q      <= elapsed_us;
						vbus_q    <= bus_reading;
						shunt_q   <= neg_shunt;
						oc_grow_q <= shunt_mag > {2'b00, cur_limit_q};
						uv_grow_q <= bus_reading < vol_limit_q;
						cnt_q     <= cnt_q + 8'd1;
						state_q   <= ST_CUR;
					end
				end
				ST_CUR: begin
					cur_time_q <= alu_rsp.res[30:0];
					state_q    <= ST_CUR_CMP;
				end
				ST_CUR_CMP: begin
					oc_q    <= alu_rsp.gt;
					state_q <= ST_VOL;
				end
				ST_VOL: begin
					vol_time_q <= alu_rsp.res[30:0];
					state_q    <= ST_VOL_CMP;
				end
				ST_VOL_CMP: begin
					uv_q    <= alu_rsp.gt;
					state_q <= ST_ENERGY;
				end
				ST_ENERGY: begin
					energy_q <= alu_rsp.res;
					state_q  <= ST_DONE;
				end
				ST_DONE: begin
					// hold until the output register is free
					if (!out_valid_q || !out_stall) begin
						out_valid_q     <= 1'b1;
						over_current_q  <= oc_q;
						under_voltage_q <= uv_q;
						shunt_value_q   <= shunt_q;
						energy_total_q  <= energy_q;
						sample_count_q  <= cnt_q;
						state_q         <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign over_current  = over_current_q;
	assign under_voltage = under_voltage_q;
	assign shunt_value   = shunt_value_q;
	assign energy_total  = energy_total_q;
	assign sample_count  = sample_count_q;

endmodule

FILE: rtl/core/pfem_checker.sv
`timescale 1ns / 1ps
`include "power_fault_energy_monitor_top_macros.svh"

module pfem_checker
	import pfem_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input logic signed [63:0] energy_total,
	input logic [7:0]         sample_count
);

	// one sample at a time: busy right after a word is taken
	`PFEM_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)

	// a result never shows up the cycle after its sample enters
	`PFEM_ASSERT_NEXT(a_no_early_result, in_valid && !in_stall, !$rose(out_valid))

	// a fresh result leaves the sequencer idle and ready
	`PFEM_ASSERT_NOW(a_ready_on_result, $rose(out_valid), !in_stall)

	`PFEM_ASSERT_NEXT(a_hold_word, out_valid && out_stall,
		out_valid && $stable(energy_total) && $stable(sample_count))

endmodule

bind power_fault_energy_monitor_top pfem_checker u_pfem_checker (.*);

FILE: bench/power_fault_energy_monitor_checker.sv
`timescale 1ns / 1ps

module power_fault_energy_monitor_checker
	import pfem_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  in_stall,
	input  logic [15:0]           elapsed_us,
	input  logic [15:0]           bus_reading,
	input  logic signed [15:0]    shunt_reading,
	input  logic                  out_valid,
	input  logic                  out_stall,
	input  logic                  over_current,
	input  logic                  under_voltage,
	input  logic signed [15:0]    shunt_value,
	input  logic signed [63:0]    energy_total,
	input  logic [7:0]            sample_count,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    pending_words,
	output int                    mismatches
);

	localparam longint ENERGY_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam longint ENERGY_MIN = 64'sh8000_0000_0000_0000;

	typedef struct {
		logic               over_current;
		logic               under_voltage;
		logic signed [15:0] shunt_value;
		logic signed [63:0] energy_total;
		logic [7:0]         sample_count;
	} monitor_word_t;

	logic [14:0]   cur_limit;
	logic [30:0]   cur_tlimit;
	logic [15:0]   vol_limit;
	logic [30:0]   vol_tlimit;
	logic [30:0]   cur_fault_us;
	logic [30:0]   vol_fault_us;
	longint        energy_acc;
	logic [7:0]    sample_cnt;
	monitor_word_t expected_words[$];

	// grow with a ceiling at ACC_MAX, shrink with a floor at zero
	function automatic logic [30:0] leak_time(logic [30:0] acc, logic grow, logic [15:0] dt);
		logic [31:0] sum;
		sum = {1'b0, acc} + {16'd0, dt};
		if (grow)
			return (sum > {1'b0, ACC_MAX}) ? ACC_MAX : sum[30:0];
		return (acc > {15'd0, dt}) ? acc - {15'd0, dt} : 31'd0;
	endfunction

	function automatic monitor_word_t predict_sample(logic [15:0] dt, logic [15:0] bus,
			logic [15:0] raw);
		logic signed [15:0] neg;
		int                 mag;
		longint             prod;
		monitor_word_t      w;
		neg = 16'd0 - raw;
		mag = (neg < 0) ? -int'(neg) : int'(neg);
		sample_cnt = sample_cnt + 8'd1;
		cur_fault_us = leak_time(cur_fault_us, mag > int'(cur_limit), dt);
		vol_fault_us = leak_time(vol_fault_us, bus < vol_limit, dt);
		prod = longint'(dt) * longint'(bus) * longint'(neg);
		if (prod > 0 && energy_acc > ENERGY_MAX - prod)
			energy_acc = ENERGY_MAX;
		else if (prod < 0 && energy_acc < ENERGY_MIN - prod)
			energy_acc = ENERGY_MIN;
		else
			energy_acc = energy_acc + prod;
		w.over_current  = cur_fault_us > cur_tlimit;
		w.under_voltage = vol_fault_us > vol_tlimit;
		w.shunt_value   = neg;
		w.energy_total  = energy_acc;
		w.sample_count  = sample_cnt;
		return w;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		monitor_word_t want;
		if (!arst_n) begin
			cur_limit    = CUR_LIMIT_RST;
			cur_tlimit   = CUR_TLIMIT_RST;
			vol_limit    = VOL_LIMIT_RST;
			vol_tlimit   = VOL_TLIMIT_RST;
			cur_fault_us = '0;
			vol_fault_us = '0;
			energy_acc   = 0;
			sample_cnt   = '0;
			expected_words.delete();
			pending_words = 0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_idx_t'(cfg_index))
					REG_CUR_LIMIT:  cur_limit  = cfg_data[14:0];
					REG_CUR_TLIMIT: cur_tlimit = cfg_data[30:0];
					REG_VOL_LIMIT:  vol_limit  = cfg_data[15:0];
					REG_VOL_TLIMIT: vol_tlimit = cfg_data[30:0];
				endcase
			end
			// compare before queueing, so a word can never match its own sample
			if (out_valid && !out_stall) begin
				if (expected_words.size() == 0) begin
					if (mismatches < 10)
						$display("%0t: result word with nothing expected", $time);
					mismatches++;
				end else begin
					want = expected_words.pop_front();
					if (over_current !== want.over_current ||
							under_voltage !== want.under_voltage ||
							shunt_value !== want.shunt_value ||
							energy_total !== want.energy_total ||
							sample_count !== want.sample_count) begin
						if (mismatches < 10)
							$display({"%0t: mismatch, expected oc=%0b uv=%0b shunt=%0d ",
								"energy=%0d count=%0d, got oc=%0b uv=%0b shunt=%0d ",
								"energy=%0d count=%0d"}, $time,
								want.over_current, want.under_voltage, want.shunt_value,
								want.energy_total, want.sample_count,
								over_current, under_voltage, shunt_value,
								energy_total, sample_count);
						mismatches++;
					end
				end
			end
			if (in_valid && !in_stall)
				expected_words.push_back(predict_sample(elapsed_us, bus_reading, shunt_reading));
			pending_words = expected_words.size();
		end
	end

endmodule

FILE: bench/power_fault_energy_monitor_top_tb.sv
`timescale 1ns / 1ps

module power_fault_energy_monitor_top_tb;
	import pfem_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 2_000_000;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic [15:0]           elapsed_us = '0;
	logic [15:0]           bus_reading = '0;
	logic signed [15:0]    shunt_reading = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic                  over_current;
	logic                  under_voltage;
	logic signed [15:0]    shunt_value;
	logic signed [63:0]    energy_total;
	logic [7:0]            sample_count;
	logic                  cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	int          pending_words;
	int          mismatches;
	int unsigned send_gap_pct = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned samples_sent = 0;
	int unsigned cycle_count = 0;
	logic [14:0] cur_lim_set = CUR_LIMIT_RST;
	logic [15:0] vol_lim_set = VOL_LIMIT_RST;

	power_fault_energy_monitor_top dut (.*);

	power_fault_energy_monitor_checker monitor_chk (.*);

	always #5ns clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	always @(negedge clk)
		out_stall <= ($urandom_range(99, 0) < recv_stall_pct);

	// called at a falling edge; returns at the falling edge after acceptance
	task automatic send_sample(logic [15:0] dt, logic [15:0] bus, logic [15:0] raw);
		while ($urandom_range(99, 0) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid      <= 1'b1;
		elapsed_us    <= dt;
		bus_reading   <= bus;
		shunt_reading <= raw;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		samples_sent++;
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_words != 0)
			@(negedge clk);
		repeat (2) @(negedge clk);
	endtask

	// the two narrow limit registers get random filler above their width to check masking
	task automatic load_limits(logic [14:0] cl, logic [30:0] ctl, logic [15:0] vl,
			logic [30:0] vtl);
		cfg_idx_t r;
		r = REG_CUR_LIMIT;
		repeat (4) begin
			cfg_wr_en <= 1'b1;
			cfg_index <= r;
			case (r)
				REG_CUR_LIMIT:  cfg_data <= {16'($urandom), cl};
				REG_CUR_TLIMIT: cfg_data <= ctl;
				REG_VOL_LIMIT:  cfg_data <= {15'($urandom), vl};
				REG_VOL_TLIMIT: cfg_data <= vtl;
			endcase
			r = r.next();
			@(negedge clk);
		end
		cfg_wr_en <= 1'b0;
		cur_lim_set = cl;
		vol_lim_set = vl;
	endtask

	// a run of samples that all push the accumulators the same way, with some noise
	task automatic send_run();
		int          len;
		int          dt_kind;
		int          mag;
		logic        want_oc;
		logic        want_uv;
		logic [15:0] dt;
		logic [15:0] bus;
		logic [15:0] raw;
		len     = $urandom_range(24, 1);
		dt_kind = $urandom_range(2, 0);
		want_oc = 1'($urandom_range(1, 0));
		want_uv = 1'($urandom_range(1, 0));
		repeat (len) begin
			case (dt_kind)
				0:       dt = 16'($urandom);
				1:       dt = 16'($urandom_range(255, 0));
				default: dt = 16'($urandom_range(65535, 49152));
			endcase
			if ($urandom_range(9, 0) == 0) begin
				bus = 16'($urandom);
				raw = 16'($urandom);
			end else begin
				if ($urandom_range(7, 0) == 0)
					mag = want_oc ? int'(cur_lim_set) + 1 : int'(cur_lim_set);
				else if (want_oc)
					mag = $urandom_range(32768, int'(cur_lim_set) + 1);
				else
					mag = $urandom_range(int'(cur_lim_set), 0);
				raw = $urandom_range(1, 0) ? 16'(mag) : 16'(-mag);
				if (want_uv && vol_lim_set != 0)
					bus = 16'($urandom_range(int'(vol_lim_set) - 1, 0));
				else if (!want_uv)
					bus = 16'($urandom_range(65535, int'(vol_lim_set)));
				else
					bus = 16'($urandom);
			end
			send_sample(dt, bus, raw);
		end
	endtask

	task automatic random_phase(int unsigned n);
		int unsigned stop_at;
		stop_at = samples_sent + n;
		while (samples_sent < stop_at)
			send_run();
	endtask

	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_gap_pct   = 25;
		recv_stall_pct = 59;
		// reset limits: over-current above 20000, no under-voltage tracking
		send_sample(16'h0000, 16'h0000, 16'h0000);
		send_sample(16'hFFFF, 16'hFFFF, 16'h8000);
		send_sample(16'hFFFF, 16'hFFFF, 16'h8000);
		send_sample(16'hFFFF, 16'h0000, 16'h8001);
		send_sample(16'hFFFF, 16'hFFFF, 16'd20000);
		send_sample(16'hFFFF, 16'h1234, 16'hB1DF);  // -20001, just above the limit
		repeat (4) send_sample(16'hFFFF, 16'hFFFF, 16'h0000);
		send_sample(16'h0001, 16'hFFFF, 16'h0001);
		send_sample(16'hAAAA, 16'h5555, 16'h5555);
		send_sample(16'h5555, 16'hAAAA, 16'hAAAA);
		drain();

		load_limits(15'd0, 31'd0, 16'hFFFF, 31'd0);
		send_sample(16'h0001, 16'hFFFE, 16'h0001);
		send_sample(16'h0000, 16'hFFFE, 16'h0001);
		send_sample(16'h0001, 16'hFFFF, 16'h0000);
		send_sample(16'h0000, 16'h0000, 16'h0000);
		drain();

		load_limits(15'h7FFF, ACC_MAX, 16'd0, ACC_MAX);
		send_sample(16'hFFFF, 16'h0000, 16'h8001);
		send_sample(16'hFFFF, 16'h0000, 16'h8000);
		send_sample(16'hFFFF, 16'h0000, 16'h7FFF);
		drain();

		load_limits(15'($urandom), 31'($urandom_range(400000, 0)), 16'($urandom),
			31'($urandom_range(400000, 0)));
		random_phase(230);
		drain();

		send_gap_pct   = 59;
		recv_stall_pct = 25;
		load_limits(15'h7FFF, 31'($urandom_range(300000, 0)), 16'($urandom_range(65535, 1)),
			31'($urandom_range(300000, 0)));
		random_phase(230);
		drain();

		send_gap_pct   = 0;
		recv_stall_pct = 0;
		load_limits(15'($urandom_range(2000, 0)), 31'($urandom_range(200000, 0)),
			16'($urandom_range(65535, 60000)), 31'($urandom_range(200000, 0)));
		random_phase(230);
		drain();

		// push energy negative with large steps and grow both accumulators
		load_limits(15'($urandom), ACC_MAX, 16'hFFFF, ACC_MAX - 31'd1);
		repeat (20) send_sample(16'hFFFF, 16'hFFFE, 16'h8000);
		repeat (3) send_sample(16'hFFFF, 16'hFFFE, 16'h8001);
		repeat (3) send_sample(16'hFFFF, 16'hFFFF, 16'h0000);
		drain();

		repeat (12) @(negedge clk);
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

FILE: power_fault_energy_monitor_top.f
+incdir+rtl/core
rtl/core/pfem_pkg.sv
rtl/core/pfem_mul.sv
rtl/core/pfem_alu.sv
rtl/core/power_fault_energy_monitor_top.sv
rtl/core/pfem_checker.sv
bench/power_fault_energy_monitor_checker.sv
bench/power_fault_energy_monitor_top_tb.sv
